[rtl/qh_pkg.sv]
// Shared types and constants for the 2D convex hull block.
// No dependencies.
`default_nettype none

package qh_pkg;

	// what the shared scan loop does with each cross product
	typedef enum logic {
		SCAN_PART,
		SCAN_FAR
	} scan_mode_t;

	// sets smaller than this produce a single no-hull beat
	localparam int MIN_HULL_POINTS = 3;

endpackage

`default_nettype wire

[rtl/quickhull_2d.sv]
// QuickHull over a loaded 2D point set; one sequencer around a shared multiplier.
// Depends on qh_pkg (scan mode type, minimum hull size).
`default_nettype none

// Points load one per cycle on the input stream; the beat with tlast set starts the hull
// and the input stays not ready until the final hull vertex has been handed to the output
// register. The hull work runs on one point memory (one read, one write port) and one
// multiplier: every point visited by a scan goes through a read, two multiply steps and a
// compare, and every swap adds two reads and two writes; hull time grows with the points
// visited over all scan and partition passes, between linear and quadratic in the point
// count. The leftmost and rightmost points are emitted first, then the farthest points in
// depth-first order. Fewer than three points give one beat with vertex_valid low.
module quickhull_2d #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16,
	localparam int TDW = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire logic [TDW-1:0] s_axis_tdata,  // px, py
	input  wire logic           s_axis_tlast,  // last_point
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic [TDW-1:0]      m_axis_tdata,  // hx, hy
	output logic                m_axis_tuser,  // vertex_valid
	output logic                m_axis_tlast   // last_vertex
);

	localparam int CB  = COORD_BITS;
	localparam int PTW = 2 * CB;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SD  = MAX_POINTS + 4;
	localparam int SAW = $clog2(SD);
	localparam int SPW = $clog2(SD + 1);
	localparam int DW  = CB + 1;
	localparam int PW  = 2 * DW;
	localparam int XW  = PW + 1;

	typedef enum logic [5:0] {
		S_LOAD, S_FEW, S_MM0, S_MM1, S_MMR, S_MMC, S_EA, S_EB, S_X1, S_X2,
		S_P1, S_P2, S_P3, S_P4, S_POP, S_POP2, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6,
		S_END, S_EMIT, S_RD, S_M1, S_M2, S_EV, S_SW0, S_SW1, S_SW2, S_SW3
	} state_t;

	state_t state_q, ret_q, sret_q;
	qh_pkg::scan_mode_t mode_q;

	// point memory
	logic [PTW-1:0] pmem [MAX_POINTS];
	logic [PTW-1:0] mem_q;
	logic [AW-1:0]  raddr, waddr;
	logic           we;
	logic [PTW-1:0] wdata;

	// segment stack memory
	logic [CW-1:0]  stk_lo [SD];
	logic [CW-1:0]  stk_hi [SD];
	logic [PTW-1:0] stk_a  [SD];
	logic [PTW-1:0] stk_b  [SD];
	logic [CW-1:0]  stk_lo_q, stk_hi_q;
	logic [PTW-1:0] stk_a_q, stk_b_q;
	logic           swe;
	logic [CW-1:0]  sw_lo, sw_hi;
	logic [PTW-1:0] sw_a, sw_b;
	logic [SAW-1:0] sraddr;

	logic [CW-1:0]  cnt_q, n_q, i_q, k_q, hi_q, split_q, lp_q, mn_q, mx_q, sa_q, sb_q;
	logic [CW-1:0]  idx_q, slo_q, shi_q;
	logic [SPW-1:0] sp_q;
	logic [PTW-1:0] pa_q, pb_q, tmp_q, pt_q, bestpt_q, em_q, pend_q, sa_pt_q, sb_pt_q;
	logic [PTW-1:0] la_q;
	logic signed [DW-1:0] ldx_q, ldy_q;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] cross_q, best_q;
	logic           found_q, pend_v_q;
	logic           m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [PTW-1:0] m_data_q;

	logic           in_acc, ofree, push_ok, m_load;
	logic [CW-1:0]  n_new;
	logic signed [DW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	function automatic logic signed [CB-1:0] xof(input logic [PTW-1:0] p);
		return $signed(p[CB-1:0]);
	endfunction

	function automatic logic signed [CB-1:0] yof(input logic [PTW-1:0] p);
		return $signed(p[PTW-1:CB]);
	endfunction

	function automatic logic signed [DW-1:0] dif(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b);
		logic signed [DW-1:0] ea, eb;
		ea = DW'(a);
		eb = DW'(b);
		return ea - eb;
	endfunction

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign ofree   = !m_tvalid_q || m_axis_tready;
	assign n_new   = (cnt_q < CW'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
	assign push_ok = (sw_lo < sw_hi) && (sp_q < SPW'(SD));
	// output register takes a new beat this cycle
	assign m_load  = ofree && ((state_q == S_FEW) || (state_q == S_END)
		|| (state_q == S_EMIT && pend_v_q));

	assign s_axis_tready = (state_q == S_LOAD);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = TDW'(m_data_q);
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	// shared multiplier: first step uses the fresh read, second the held point
	always_comb begin
		if (state_q == S_M1) begin
			mul_b = dif(yof(mem_q), yof(la_q));
			mul_p = PW'(ldx_q) * PW'(mul_b);
		end else begin
			mul_b = dif(xof(pt_q), xof(la_q));
			mul_p = PW'(ldy_q) * PW'(mul_b);
		end
	end

	always_comb begin
		raddr  = i_q[AW-1:0];
		we     = 1'b0;
		waddr  = cnt_q[AW-1:0];
		wdata  = {s_axis_tdata[PTW-1:CB], s_axis_tdata[CB-1:0]};
		swe    = 1'b0;
		sw_lo  = split_q;
		sw_hi  = k_q;
		sw_a   = pb_q;
		sw_b   = pa_q;
		sraddr = SAW'(sp_q - 1'b1);
		case (state_q)
			S_LOAD: we = in_acc && (cnt_q < CW'(MAX_POINTS));
			S_MM0:  raddr = '0;
			S_SW0:  raddr = sa_q[AW-1:0];
			S_SW1:  raddr = sb_q[AW-1:0];
			S_SW2: begin
				we    = 1'b1;
				waddr = sa_q[AW-1:0];
				wdata = mem_q;
			end
			S_SW3: begin
				we    = 1'b1;
				waddr = sb_q[AW-1:0];
				wdata = tmp_q;
			end
			S_P3: swe = 1'b1;
			S_P4: begin
				sw_lo = CW'(2);
				sw_hi = split_q;
				sw_a  = pa_q;
				sw_b  = pb_q;
				swe   = 1'b1;
			end
			S_F5: begin
				sw_lo = lp_q;
				sw_hi = k_q;
				sw_a  = bestpt_q;
				sw_b  = sb_pt_q;
				swe   = 1'b1;
			end
			S_F6: begin
				sw_lo = slo_q + 1'b1;
				sw_hi = lp_q;
				sw_a  = sa_pt_q;
				sw_b  = bestpt_q;
				swe   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) pmem[waddr] <= wdata;
		mem_q <= pmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (swe && push_ok) begin
			stk_lo[sp_q[SAW-1:0]] <= sw_lo;
			stk_hi[sp_q[SAW-1:0]] <= sw_hi;
			stk_a[sp_q[SAW-1:0]]  <= sw_a;
			stk_b[sp_q[SAW-1:0]]  <= sw_b;
		end
		stk_lo_q <= stk_lo[sraddr];
		stk_hi_q <= stk_hi[sraddr];
		stk_a_q  <= stk_a[sraddr];
		stk_b_q  <= stk_b[sraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			ret_q      <= S_LOAD;
			sret_q     <= S_LOAD;
			mode_q     <= qh_pkg::SCAN_PART;
			cnt_q      <= '0;
			sp_q       <= '0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (m_axis_tready && !m_load) m_tvalid_q <= 1'b0;
			if (swe && push_ok) sp_q <= sp_q + 1'b1;
			case (state_q)
				S_LOAD: if (in_acc) begin
					if (s_axis_tlast) begin
						cnt_q <= '0;
						n_q   <= n_new;
						state_q <= (n_new < CW'(qh_pkg::MIN_HULL_POINTS)) ? S_FEW : S_MM0;
					end else begin
						cnt_q <= n_new;
					end
				end
				S_FEW: if (ofree) begin
					m_tvalid_q <= 1'b1;
					m_data_q   <= '0;
					m_tuser_q  <= 1'b0;
					m_tlast_q  <= 1'b1;
					state_q    <= S_LOAD;
				end
				S_MM0: begin
					i_q     <= CW'(1);
					state_q <= S_MM1;
				end
				S_MM1: begin
					pa_q    <= mem_q;
					pb_q    <= mem_q;
					mn_q    <= '0;
					mx_q    <= '0;
					state_q <= S_MMR;
				end
				S_MMR: state_q <= (i_q >= n_q) ? S_EA : S_MMC;
				S_MMC: begin
					if (xof(mem_q) < xof(pa_q)) begin
						pa_q <= mem_q;
						mn_q <= i_q;
					end
					if (xof(mem_q) > xof(pb_q)) begin
						pb_q <= mem_q;
						mx_q <= i_q;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_MMR;
				end
				S_EA: begin
					em_q    <= pa_q;
					ret_q   <= S_EB;
					state_q <= S_EMIT;
				end
				S_EB: begin
					em_q    <= pb_q;
					ret_q   <= S_X1;
					state_q <= S_EMIT;
				end
				S_X1: begin
					sa_q    <= '0;
					sb_q    <= mn_q;
					sret_q  <= S_X2;
					state_q <= S_SW0;
				end
				S_X2: begin
					sa_q    <= CW'(1);
					sb_q    <= (mx_q == '0) ? mn_q : mx_q;
					sret_q  <= S_P1;
					state_q <= S_SW0;
				end
				S_P1: begin
					la_q    <= pa_q;
					ldx_q   <= dif(xof(pb_q), xof(pa_q));
					ldy_q   <= dif(yof(pb_q), yof(pa_q));
					i_q     <= CW'(2);
					k_q     <= CW'(2);
					hi_q    <= n_q;
					mode_q  <= qh_pkg::SCAN_PART;
					ret_q   <= S_P2;
					state_q <= S_RD;
				end
				S_P2: begin
					// below pa->pb is above pb->pa
					split_q <= k_q;
					la_q    <= pb_q;
					ldx_q   <= dif(xof(pa_q), xof(pb_q));
					ldy_q   <= dif(yof(pa_q), yof(pb_q));
					i_q     <= k_q;
					ret_q   <= S_P3;
					state_q <= S_RD;
				end
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_POP;
				S_POP: if (sp_q == '0) begin
					state_q <= S_END;
				end else begin
					sp_q    <= sp_q - 1'b1;
					state_q <= S_POP2;
				end
				S_POP2: begin
					slo_q   <= stk_lo_q;
					shi_q   <= stk_hi_q;
					sa_pt_q <= stk_a_q;
					sb_pt_q <= stk_b_q;
					la_q    <= stk_a_q;
					ldx_q   <= dif(xof(stk_b_q), xof(stk_a_q));
					ldy_q   <= dif(yof(stk_b_q), yof(stk_a_q));
					i_q     <= stk_lo_q;
					k_q     <= stk_lo_q;
					hi_q    <= stk_hi_q;
					best_q  <= '0;
					found_q <= 1'b0;
					mode_q  <= qh_pkg::SCAN_FAR;
					ret_q   <= S_F1;
					state_q <= S_RD;
				end
				S_F1: if (!found_q) begin
					state_q <= S_POP;
				end else begin
					em_q    <= bestpt_q;
					ret_q   <= S_F2;
					state_q <= S_EMIT;
				end
				S_F2: begin
					sa_q    <= slo_q;
					sb_q    <= idx_q;
					sret_q  <= S_F3;
					state_q <= S_SW0;
				end
				S_F3: begin
					la_q    <= sa_pt_q;
					ldx_q   <= dif(xof(bestpt_q), xof(sa_pt_q));
					ldy_q   <= dif(yof(bestpt_q), yof(sa_pt_q));
					i_q     <= slo_q + 1'b1;
					k_q     <= slo_q + 1'b1;
					mode_q  <= qh_pkg::SCAN_PART;
					ret_q   <= S_F4;
					state_q <= S_RD;
				end
				S_F4: begin
					lp_q    <= k_q;
					la_q    <= bestpt_q;
					ldx_q   <= dif(xof(sb_pt_q), xof(bestpt_q));
					ldy_q   <= dif(yof(sb_pt_q), yof(bestpt_q));
					i_q     <= k_q;
					ret_q   <= S_F5;
					state_q <= S_RD;
				end
				// right segment pushed first so the left one pops first
				S_F5: state_q <= S_F6;
				S_F6: state_q <= S_POP;
				S_END: if (ofree) begin
					m_tvalid_q <= 1'b1;
					m_data_q   <= pend_q;
					m_tuser_q  <= 1'b1;
					m_tlast_q  <= 1'b1;
					pend_v_q   <= 1'b0;
					state_q    <= S_LOAD;
				end
				// hold one vertex back so the final beat can carry tlast
				S_EMIT: if (!pend_v_q) begin
					pend_q   <= em_q;
					pend_v_q <= 1'b1;
					state_q  <= ret_q;
				end else if (ofree) begin
					m_tvalid_q <= 1'b1;
					m_data_q   <= pend_q;
					m_tuser_q  <= 1'b1;
					m_tlast_q  <= 1'b0;
					pend_q     <= em_q;
					state_q    <= ret_q;
				end
				S_RD: state_q <= (i_q >= hi_q) ? ret_q : S_M1;
				S_M1: begin
					pt_q    <= mem_q;
					prod_q  <= mul_p;
					state_q <= S_M2;
				end
				S_M2: begin
					cross_q <= XW'(prod_q) - XW'(mul_p);
					state_q <= S_EV;
				end
				S_EV: begin
					i_q <= i_q + 1'b1;
					if (mode_q == qh_pkg::SCAN_PART && cross_q > 0) begin
						sa_q    <= i_q;
						sb_q    <= k_q;
						k_q     <= k_q + 1'b1;
						sret_q  <= S_RD;
						state_q <= S_SW0;
					end else begin
						state_q <= S_RD;
						if (mode_q == qh_pkg::SCAN_FAR && cross_q > best_q) begin
							best_q   <= cross_q;
							idx_q    <= i_q;
							bestpt_q <= pt_q;
							found_q  <= 1'b1;
						end
					end
				end
				S_SW0: state_q <= S_SW1;
				S_SW1: begin
					tmp_q   <= mem_q;
					state_q <= S_SW2;
				end
				S_SW2: state_q <= S_SW3;
				S_SW3: state_q <= sret_q;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count beyond store");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD)) else $error("segment stack overflow");
	a_end_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_END |-> pend_v_q) else $error("hull end with no held vertex");
	a_part_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV && mode_q == qh_pkg::SCAN_PART) |-> k_q <= i_q)
		else $error("partition split passed scan index");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tlast) |=> !s_axis_tready) else $error("ready during hull");

endmodule

`default_nettype wire

[tb/tb_quickhull_2d.sv]
// Testbench for quickhull_2d: streams point sets in, checks every hull vertex beat.
// Depends on rtl/qh_pkg.sv and rtl/quickhull_2d.sv; vertices are predicted in-bench.
`default_nettype none

module tb_quickhull_2d;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 64;
	localparam int CB = 16;
	localparam int TDW = 32;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
	} point_t;

	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic          valid;
		logic          last;
	} vertex_t;

	typedef struct {
		int     lo;
		int     hi;
		point_t a;
		point_t b;
	} span_t;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 last;
		bit                   chk;
		vertex_t              ev;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [TDW-1:0] s_axis_tdata = '0;  // px, py
	logic s_axis_tlast = 0;             // last_point
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [TDW-1:0] m_axis_tdata;       // hx, hy
	logic m_axis_tuser;                 // vertex_valid
	logic m_axis_tlast;                 // last_vertex

	quickhull_2d DUT (.*);

	always #6 clk = ~clk;

	point_t  pts [NPTS];
	int      npts_loaded = 0;
	vertex_t hull_q [$];
	vertex_t typed_q [$];
	int      errors = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	longint  cycles = 0;

	function automatic longint cross_p(point_t a, point_t b, point_t p);
		return (longint'(b.x) - a.x) * (longint'(p.y) - a.y)
			- (longint'(b.y) - a.y) * (longint'(p.x) - a.x);
	endfunction

	function automatic void swap_pts(int i, int j);
		point_t t;
		t = pts[i];
		pts[i] = pts[j];
		pts[j] = t;
	endfunction

	function automatic int side_split(int lo, int hi, point_t a, point_t b, bit above);
		int k;
		longint d;
		k = lo;
		for (int i = lo; i < hi; i++) begin
			d = cross_p(a, b, pts[i]);
			if (above ? (d > 0) : (d < 0)) begin
				swap_pts(i, k);
				k++;
			end
		end
		return k;
	endfunction

	function automatic void add_vertex(point_t p);
		vertex_t v;
		v.x = p.x;
		v.y = p.y;
		v.valid = 1;
		v.last = 0;
		hull_q.insert(hull_q.size(), v);
	endfunction

	// absorb one point; on the final one, queue the hull vertices it produces
	function automatic void hull_predict(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
			logic last);
		int n, mn, mx, s1, s2, idx, w, lp, rp;
		longint best, d;
		point_t pa, pb, c;
		span_t stk [$];
		span_t sp;
		vertex_t v;
		if (npts_loaded < NPTS) begin
			pts[npts_loaded].x = x;
			pts[npts_loaded].y = y;
			npts_loaded++;
		end
		if (!last) return;
		n = npts_loaded;
		npts_loaded = 0;
		if (n < qh_pkg::MIN_HULL_POINTS) begin
			v = '{x: '0, y: '0, valid: 0, last: 1};
			hull_q.insert(hull_q.size(), v);
			return;
		end
		mn = 0;
		mx = 0;
		for (int i = 1; i < n; i++) begin
			if (pts[i].x < pts[mn].x) mn = i;
			if (pts[i].x > pts[mx].x) mx = i;
		end
		pa = pts[mn];
		pb = pts[mx];
		add_vertex(pa);
		add_vertex(pb);
		swap_pts(0, mn);
		if (mx == 0) mx = mn;
		swap_pts(1, mx);
		s1 = side_split(2, n, pa, pb, 1);
		s2 = side_split(s1, n, pa, pb, 0);
		if (s1 < s2) stk.insert(stk.size(), span_t'{s1, s2, pb, pa});
		if (2 < s1) stk.insert(stk.size(), span_t'{2, s1, pa, pb});
		while (stk.size() > 0) begin
			sp = stk.pop_back();
			best = -1;
			idx = -1;
			for (int i = sp.lo; i < sp.hi; i++) begin
				d = cross_p(sp.a, sp.b, pts[i]);
				if (d > best) begin
					best = d;
					idx = i;
				end
			end
			if (idx < 0 || best <= 0) continue;
			c = pts[idx];
			add_vertex(c);
			swap_pts(sp.lo, idx);
			w = sp.lo + 1;
			lp = side_split(w, sp.hi, sp.a, c, 1);
			rp = side_split(lp, sp.hi, c, sp.b, 1);
			if (lp < rp) stk.insert(stk.size(), span_t'{lp, rp, c, sp.b});
			if (w < lp) stk.insert(stk.size(), span_t'{w, lp, sp.a, c});
		end
		hull_q[$].last = 1;
	endfunction

	// check each output beat against the oldest predicted vertex
	always @(posedge clk) begin
		vertex_t e;
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hull_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h user %b last %b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				e = hull_q.pop_front();
				if (m_axis_tdata[CB-1:0] !== e.x || m_axis_tdata[2*CB-1:CB] !== e.y
						|| m_axis_tuser !== e.valid || m_axis_tlast !== e.last) begin
					errors++;
					$display("%0t: expected x %h y %h valid %b last %b,",
						$time, e.x, e.y, e.valid, e.last,
						" got x %h y %h valid %b last %b", m_axis_tdata[CB-1:0],
						m_axis_tdata[2*CB-1:CB], m_axis_tuser, m_axis_tlast);
				end
				if (typed_q.size() > 0 && e.valid === typed_q[0].valid
						&& !e.valid) begin
					// no-hull beats also have a typed-in value
					e = typed_q.pop_front();
					if (m_axis_tdata !== {e.y, e.x} || m_axis_tuser !== e.valid
							|| m_axis_tlast !== e.last) begin
						errors++;
						$display("%0t: expected no-hull beat %h, got %h user %b last %b",
							$time, {e.y, e.x}, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// leaves the beat valid so back-to-back beats need no gap; drop valid before waiting
	task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {y, x};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		hull_predict(x, y, last);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (hull_q.size() > 0) @(negedge clk);
	endtask

	function automatic logic signed [CB-1:0] rcoord(int spread);
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return $signed(16'($urandom));
			default: return $signed(16'($urandom_range(2 * spread) - spread));
		endcase
	endfunction

	task automatic random_set(int n, int spread);
		for (int i = 0; i < n; i++)
			send_point(rcoord(spread), rcoord(spread), i == n - 1);
	endtask

	row_t dir_rows [$];

	initial begin
		// single point, two points, extremes, all x equal, collinear, square, ties
		dir_rows = '{
			'{16'sd5, 16'sd5, 1, 1, '{16'h0, 16'h0, 0, 1}},
			'{-16'sd32768, 16'sd32767, 0, 0, '{0, 0, 0, 0}},
			'{16'sd32767, -16'sd32768, 1, 1, '{16'h0, 16'h0, 0, 1}},
			'{16'sd7, -16'sd32768, 0, 0, '{0, 0, 0, 0}},
			'{16'sd7, 16'sd32767, 0, 0, '{0, 0, 0, 0}},
			'{16'sd7, 16'sd0, 1, 0, '{0, 0, 0, 0}},
			'{-16'sd32768, -16'sd32768, 0, 0, '{0, 0, 0, 0}},
			'{16'sd32767, 16'sd32767, 0, 0, '{0, 0, 0, 0}},
			'{-16'sd32768, 16'sd32767, 0, 0, '{0, 0, 0, 0}},
			'{16'sd32767, -16'sd32768, 0, 0, '{0, 0, 0, 0}},
			'{16'sd0, 16'sd0, 1, 0, '{0, 0, 0, 0}},
			'{16'sd0, 16'sd0, 0, 0, '{0, 0, 0, 0}},
			'{16'sd1, 16'sd1, 0, 0, '{0, 0, 0, 0}},
			'{16'sd2, 16'sd2, 0, 0, '{0, 0, 0, 0}},
			'{16'sd0, 16'sd0, 1, 0, '{0, 0, 0, 0}},
			'{16'sd0, 16'sd4, 0, 0, '{0, 0, 0, 0}},
			'{16'sd0, -16'sd4, 0, 0, '{0, 0, 0, 0}},
			'{16'sd4, 16'sd4, 0, 0, '{0, 0, 0, 0}},
			'{16'sd4, -16'sd4, 0, 0, '{0, 0, 0, 0}},
			'{16'sd2, 16'sd0, 1, 0, '{0, 0, 0, 0}}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		send_idle_pct = 19;
		recv_idle_pct = 69;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].chk) typed_q.insert(typed_q.size(), dir_rows[i].ev);
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last);
		end
		// overflow the store: the flag on a dropped point still starts the hull
		for (int i = 0; i < NPTS + 3; i++)
			send_point(rcoord(300), rcoord(300), i == NPTS + 2);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 69 : 0;
			recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 19 : 0;
			for (int k = 0; k < 2; k++) begin
				random_set($urandom_range(1, 7), (k % 2) ? 20 : 30000);
			end
			wait_drained();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && hull_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
